// File: src/pwl_pkg.sv
// Package with the shared types and constants of the piecewise-linear table.
package pwl_pkg;

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_EVAL  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_REPLACED = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_FEW      = 2'd3;

    localparam int CNT_W = 7;

    // One request as it passes from the front part to the back part.
    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] x_time;
        logic signed [31:0] y_value;
    } pwl_req_t;

    typedef struct packed {
        logic signed [31:0] y_result;
        logic [1:0]         status;
        logic [CNT_W-1:0]   point_count;
    } pwl_res_t;

endpackage

// File: src/pwl_ram.sv
// Generic single-port RAM with registered read.
module pwl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// File: src/pwl_fifo.sv
// Two-entry request queue between the front and back parts.
module pwl_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  pwl_pkg::pwl_req_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output pwl_pkg::pwl_req_t out_data
);

    pwl_pkg::pwl_req_t buf_reg [2];
    logic              wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0]        cnt_reg, cnt_next;
    logic              push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = buf_reg[rp_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wp_reg] <= in_data;
        end
    end

endmodule

// File: src/pwl_back.sv
// Back part: table walk, insertion shift, serial division and result register.
module pwl_back #(
    parameter int MAX_POINTS = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  pwl_pkg::pwl_req_t req,
    output logic              res_valid,
    input  logic              res_ready,
    output pwl_pkg::pwl_res_t res
);

    localparam int AW = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
    localparam int NW = $clog2(MAX_POINTS + 1);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_RD    = 10'b0000000010,
        S_CMP   = 10'b0000000100,
        S_SHRD  = 10'b0000001000,
        S_SHWR  = 10'b0000010000,
        S_RD2   = 10'b0000100000,
        S_MUL   = 10'b0001000000,
        S_DIV   = 10'b0010000000,
        S_FIN   = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } state_t;

    state_t             st_reg, st_next;
    pwl_pkg::pwl_req_t  cur_reg, cur_next;
    logic [NW-1:0]      n_reg, n_next;
    logic [NW-1:0]      i_reg, i_next;
    logic               ph_reg, ph_next;
    logic signed [31:0] x1_reg, x1_next, y1_reg, y1_next;
    logic signed [31:0] x2_reg, x2_next, y2_reg, y2_next;
    logic [63:0]        prod_reg, prod_next;
    logic [32:0]        den_reg, den_next;
    logic [32:0]        rem_reg, rem_next;
    logic [63:0]        q_reg, q_next;
    logic [6:0]         bit_reg, bit_next;
    logic               neg_reg, neg_next;
    pwl_pkg::pwl_res_t  res_reg, res_next;
    logic               rv_reg, rv_next;

    logic          we;
    logic [AW-1:0] addr;
    logic [63:0]   wdata, rdata;
    logic signed [31:0] rt, rv;

    pwl_ram #(.WIDTH(64), .DEPTH(MAX_POINTS)) u_ram (
        .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
    );

    assign rt        = rdata[63:32];
    assign rv        = rdata[31:0];
    assign req_ready = (st_reg == S_IDLE) && !rv_reg;
    assign res_valid = rv_reg;
    assign res       = res_reg;

    logic signed [32:0] dy, dxq;
    logic [32:0]        mdy, mdx;
    logic [33:0]        rsh;
    logic signed [65:0] sum;
    logic [64:0]        qr;

    always_comb
    begin
        st_next = st_reg; cur_next = cur_reg; n_next = n_reg; i_next = i_reg;
        ph_next = ph_reg; x1_next = x1_reg; y1_next = y1_reg; x2_next = x2_reg;
        y2_next = y2_reg; prod_next = prod_reg; den_next = den_reg;
        rem_next = rem_reg; q_next = q_reg; bit_next = bit_reg; neg_next = neg_reg;
        res_next = res_reg; rv_next = rv_reg;
        we = 1'b0; addr = i_reg[AW-1:0]; wdata = {cur_reg.x_time, cur_reg.y_value};
        dy  = 33'(y2_reg) - 33'(y1_reg);
        dxq = 33'(cur_reg.x_time) - 33'(x2_reg);
        mdy = dy[32] ? 33'(-dy) : 33'(dy);
        mdx = dxq[32] ? 33'(-dxq) : 33'(dxq);
        rsh = {rem_reg, prod_reg[63]};
        qr  = 65'(q_reg) + ((({1'b0, rem_reg}) >= (34'(den_reg) - 34'(rem_reg))) ? 65'd1 : 65'd0);
        sum = neg_reg ? 66'(y2_reg) - 66'(qr) : 66'(y2_reg) + 66'(qr);
        if (rv_reg && res_ready)
        begin
            rv_next = 1'b0;
        end
        case (st_reg)
            S_IDLE:
            begin
                if (req_valid && !rv_reg)
                begin
                    cur_next = req;
                    i_next   = '0;
                    res_next.y_result = '0;
                    res_next.status   = pwl_pkg::ST_OK;
                    case (req.op)
                        pwl_pkg::OP_ADD:
                        begin
                            st_next = (n_reg == '0) ? S_SHWR : S_RD;
                            i_next  = '0;
                        end
                        pwl_pkg::OP_EVAL:
                        begin
                            if (n_reg < NW'(2))
                            begin
                                res_next.status = pwl_pkg::ST_FEW;
                                st_next = S_OUT;
                            end
                            else
                            begin
                                i_next = NW'(1);
                                st_next = S_RD;
                            end
                        end
                        pwl_pkg::OP_CLEAR:
                        begin
                            n_next  = '0;
                            st_next = S_OUT;
                        end
                        default: st_next = S_OUT;
                    endcase
                end
            end
            S_RD:
            begin
                st_next = S_CMP;
            end
            S_CMP:
            begin
                if (cur_reg.op == pwl_pkg::OP_ADD)
                begin
                    if (rt == cur_reg.x_time)
                    begin
                        we = 1'b1;
                        res_next.status = pwl_pkg::ST_REPLACED;
                        st_next = S_OUT;
                    end
                    else if (rt > cur_reg.x_time || i_reg == n_reg - NW'(1))
                    begin
                        if (n_reg >= NW'(MAX_POINTS))
                        begin
                            res_next.status = pwl_pkg::ST_FULL;
                            st_next = S_OUT;
                        end
                        else
                        begin
                            // pos is i when bigger, else the end of the table
                            if (rt < cur_reg.x_time)
                            begin
                                i_next = n_reg;
                                st_next = S_SHWR;
                            end
                            else
                            begin
                                x1_next = 32'(i_reg);
                                i_next  = n_reg;
                                st_next = S_SHRD;
                            end
                        end
                    end
                    else
                    begin
                        i_next = i_reg + NW'(1);
                        addr = AW'(i_reg + NW'(1));
                        st_next = S_CMP;
                    end
                end
                else
                begin
                    // walk until the point at i is past x or i is the last
                    if (rt > cur_reg.x_time || i_reg == n_reg - NW'(1))
                    begin
                        x2_next = rt; y2_next = rv;
                        addr = AW'(i_reg - NW'(1));
                        st_next = S_RD2;
                    end
                    else
                    begin
                        i_next = i_reg + NW'(1);
                        addr = AW'(i_reg + NW'(1));
                    end
                end
            end
            S_SHRD:
            begin
                // shift entries up one place, from the end down to pos
                if (i_reg == NW'(x1_reg))
                begin
                    st_next = S_SHWR;
                end
                else
                begin
                    addr = AW'(i_reg - NW'(1));
                    if (ph_reg)
                    begin
                        we = 1'b1; addr = i_reg[AW-1:0]; wdata = rdata;
                        i_next = i_reg - NW'(1); ph_next = 1'b0;
                    end
                    else
                    begin
                        ph_next = 1'b1;
                    end
                end
            end
            S_SHWR:
            begin
                we = 1'b1;
                n_next = n_reg + NW'(1);
                st_next = S_OUT;
            end
            S_RD2:
            begin
                x1_next = rt; y1_next = rv;
                st_next = S_MUL;
            end
            S_MUL:
            begin
                prod_next = 64'(mdy[31:0]) * 64'(mdx[31:0]);
                if (mdy[32]) prod_next = prod_next + {mdx[31:0], 32'd0};
                if (mdx[32]) prod_next = prod_next + {mdy[31:0], 32'd0};
                neg_next = dy[32] != dxq[32];
                den_next = 33'(x2_reg) - 33'(x1_reg);
                rem_next = '0; q_next = '0; bit_next = 7'd64;
                st_next = S_DIV;
            end
            S_DIV:
            begin
                prod_next = {prod_reg[62:0], 1'b0};
                if (rsh >= 34'(den_reg))
                begin
                    rem_next = 33'(rsh - 34'(den_reg));
                    q_next = {q_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_next = rsh[32:0];
                    q_next = {q_reg[62:0], 1'b0};
                end
                bit_next = bit_reg - 7'd1;
                if (bit_reg == 7'd1) st_next = S_FIN;
            end
            S_FIN:
            begin
                if (qr > 65'h400000000)
                    res_next.y_result = neg_reg ? 32'sh80000000 : 32'sh7fffffff;
                else if (sum > 66'sh7fffffff)
                    res_next.y_result = 32'sh7fffffff;
                else if (sum < -66'sh80000000)
                    res_next.y_result = 32'sh80000000;
                else
                    res_next.y_result = sum[31:0];
                st_next = S_OUT;
            end
            S_OUT:
            begin
                res_next.point_count = pwl_pkg::CNT_W'(n_reg);
                rv_next = 1'b1;
                st_next = S_IDLE;
            end
            default: st_next = S_IDLE;
        endcase
        if (st_reg == S_SHWR) addr = AW'(cur_reg.op == pwl_pkg::OP_ADD ? i_reg : i_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE; n_reg <= '0; rv_reg <= 1'b0; ph_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next; n_reg <= n_next; rv_reg <= rv_next; ph_reg <= ph_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next; i_reg <= i_next; x1_reg <= x1_next; y1_reg <= y1_next;
        x2_reg <= x2_next; y2_reg <= y2_next; prod_reg <= prod_next;
        den_reg <= den_next; rem_reg <= rem_next; q_reg <= q_next;
        bit_reg <= bit_next; neg_reg <= neg_next; res_reg <= res_next;
    end

endmodule

// File: src/piecewise_linear_table_interp.sv
// Top level of the piecewise-linear interpolation table.
// Requests enter on the s_axis channel: tdata holds x_time (bits 31:0) and
// y_value (bits 63:32), tuser holds op. Add inserts or replaces a point,
// evaluate interpolates at x_time, clear empties the table.
// Every request gives one result on m_axis: tdata holds y_result (31:0),
// status (33:32) and point_count (40:34), padded to 48 bits.
// A small queue takes requests while the back part works, so the sender
// sees ready while an earlier request is still being processed.
// The back part handles one request at a time. Clear goes straight to the
// result; add walks the table and then shifts the later points up one place;
// evaluate walks the table and then runs a serial division that gives one
// quotient bit per cycle. The single RAM port makes the walk and the shift go one point at a time.
// Reset empties the table and the queue; the points themselves are not
// cleared, since only entries below the count are read.
// When the receiver stalls, the result register holds and the back part
// waits; the queue keeps taking requests until full.
module piecewise_linear_table_interp #(
    parameter int MAX_POINTS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // x_time, y_value
    input  logic [1:0]  s_axis_tuser,  // op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata   // y_result, status, point_count, zero pad
);

    pwl_pkg::pwl_req_t in_req, q_req;
    pwl_pkg::pwl_res_t res;
    logic              q_valid, q_ready;

    assign in_req.op      = s_axis_tuser;
    assign in_req.x_time  = s_axis_tdata[31:0];
    assign in_req.y_value = s_axis_tdata[63:32];

    pwl_fifo u_fifo (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_data(in_req),
        .out_valid(q_valid), .out_ready(q_ready), .out_data(q_req)
    );

    pwl_back #(.MAX_POINTS(MAX_POINTS)) u_back (
        .clk(clk), .rst_n(rst_n),
        .req_valid(q_valid), .req_ready(q_ready), .req(q_req),
        .res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res(res)
    );

    assign m_axis_tdata = {7'd0, res.point_count, res.status, res.y_result};

    // A stalled result must hold.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed under stall");

    // The count never exceeds the table size.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> res.point_count <= 7'(MAX_POINTS))
        else $error("point count out of range");

    // Too-few status only comes with a zero result.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && res.status == pwl_pkg::ST_FEW |-> res.y_result == '0)
        else $error("too-few status with a value");

endmodule

// File: dv/pwl_checker.sv
// Checker for the interpolation table: predicts each result and compares it on the result side.
module pwl_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,
    input  logic [1:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [47:0] m_axis_tdata,
    output int          errors,
    output int          pending
);

    localparam int DEPTH = 64;

    logic signed [31:0] pt_time [DEPTH];
    logic signed [31:0] pt_value[DEPTH];
    int                 pt_count;
    pwl_pkg::pwl_res_t  awaited_q[$];

    // Line through (x1,y1),(x2,y2) evaluated at x, rounded to nearest and saturated.
    function automatic logic signed [31:0] line_value(
        logic signed [31:0] x1, logic signed [31:0] y1,
        logic signed [31:0] x2, logic signed [31:0] y2,
        logic signed [31:0] x
    );
        longint      dy;
        longint      dx;
        longint      den;
        logic [127:0] prod;
        logic [127:0] quo;
        logic [127:0] rmd;
        logic [127:0] dv;
        bit          neg;
        longint      sum;
        dy  = longint'(y2) - longint'(y1);
        dx  = longint'(x) - longint'(x2);
        den = longint'(x2) - longint'(x1);
        if (den <= 0)
            return y2;
        neg  = (dy < 0) != (dx < 0);
        prod = 128'(dy < 0 ? -dy : dy) * 128'(dx < 0 ? -dx : dx);
        dv   = 128'(den);
        quo  = prod / dv;
        rmd  = prod % dv;
        if (rmd >= dv - rmd)
            quo = quo + 1;
        if (quo > (128'd1 << 34))
            return neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
        sum = neg ? longint'(y2) - longint'(quo[63:0]) : longint'(y2) + longint'(quo[63:0]);
        if (sum > 64'sd2147483647)
            sum = 64'sd2147483647;
        if (sum < -64'sd2147483648)
            sum = -64'sd2147483648;
        return sum[31:0];
    endfunction

    // Applies one request to the table copy and returns the result it should give.
    function automatic pwl_pkg::pwl_res_t apply_request(logic [1:0] op,
                                                        logic signed [31:0] x,
                                                        logic signed [31:0] y);
        pwl_pkg::pwl_res_t res;
        int       pos;
        int       le_cnt;
        int       lo;
        bit       replaced;
        res.y_result = '0;
        res.status   = pwl_pkg::ST_OK;
        if (op == pwl_pkg::OP_ADD) begin
            pos      = pt_count;
            replaced = 1'b0;
            for (int i = 0; i < pt_count; i++) begin
                if (pt_time[i] == x) begin
                    pt_value[i] = y;
                    replaced    = 1'b1;
                    break;
                end
                if (pt_time[i] > x) begin
                    pos = i;
                    break;
                end
            end
            if (replaced)
                res.status = pwl_pkg::ST_REPLACED;
            else if (pt_count >= DEPTH)
                res.status = pwl_pkg::ST_FULL;
            else begin
                for (int i = pt_count; i > pos; i--) begin
                    pt_time[i]  = pt_time[i-1];
                    pt_value[i] = pt_value[i-1];
                end
                pt_time[pos]  = x;
                pt_value[pos] = y;
                pt_count++;
            end
        end else if (op == pwl_pkg::OP_EVAL) begin
            if (pt_count < 2)
                res.status = pwl_pkg::ST_FEW;
            else begin
                le_cnt = 0;
                for (int i = 0; i < pt_count; i++) begin
                    if (pt_time[i] > x)
                        break;
                    le_cnt = i + 1;
                end
                if (le_cnt == 0)
                    lo = 0;
                else if (le_cnt >= pt_count)
                    lo = pt_count - 2;
                else
                    lo = le_cnt - 1;
                res.y_result = line_value(pt_time[lo], pt_value[lo],
                                          pt_time[lo+1], pt_value[lo+1], x);
            end
        end else if (op == pwl_pkg::OP_CLEAR) begin
            pt_count = 0;
        end
        res.point_count = pwl_pkg::CNT_W'(pt_count);
        return res;
    endfunction

    assign pending = awaited_q.size();

    always @(posedge clk or negedge rst_n) begin
        pwl_pkg::pwl_res_t exp_res;
        pwl_pkg::pwl_res_t new_res;
        pwl_pkg::pwl_res_t got;
        if (!rst_n) begin
            pt_count = 0;
            errors   = 0;
            awaited_q.delete();
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                new_res   = apply_request(s_axis_tuser, s_axis_tdata[31:0],
                                          s_axis_tdata[63:32]);
                awaited_q = {awaited_q, new_res};
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.y_result    = m_axis_tdata[31:0];
                got.status      = m_axis_tdata[33:32];
                got.point_count = m_axis_tdata[40:34];
                if (awaited_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result %h", $time, m_axis_tdata);
                end else begin
                    exp_res = awaited_q.pop_front();
                    if (got.y_result !== exp_res.y_result) begin
                        errors++;
                        $display("%0t: y_result expected %h actual %h", $time,
                                 exp_res.y_result, got.y_result);
                    end
                    if (got.status !== exp_res.status) begin
                        errors++;
                        $display("%0t: status expected %0d actual %0d", $time,
                                 exp_res.status, got.status);
                    end
                    if (got.point_count !== exp_res.point_count) begin
                        errors++;
                        $display("%0t: point_count expected %0d actual %0d", $time,
                                 exp_res.point_count, got.point_count);
                    end
                end
            end
        end
    end

endmodule

// File: dv/tb_top.sv
// Testbench top for the interpolation table: drives requests and gives the verdict.
module tb_top;

    localparam int STALL_LIMIT = 6000;
    localparam logic [1:0] OP_SPARE = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;
    int          errors;
    int          pending;
    int          idle_cycles = 0;

    piecewise_linear_table_interp dut (.*);

    pwl_checker u_checker (.*);

    always begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Gap length: mostly short, now and then long.
    function automatic int gap_len();
        if ($urandom_range(0, 2) == 0)
            return 0;
        return ($urandom_range(0, 15) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 4);
    endfunction

    // A 32-bit word picked from extremes, numbers within +-span or the full range.
    function automatic logic [31:0] pick_word(int span);
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2, 3:    return $urandom;
            default: return 32'($signed($urandom_range(0, 2 * span)) - span);
        endcase
    endfunction

    // Presents one request and holds it until the block takes it.
    task automatic send(logic [1:0] op, logic [31:0] x, logic [31:0] y);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {y, x};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // A run of requests over one time span; add and evaluate dominate.
    task automatic run_phase(int count, int span, int add_pct);
        int roll;
        for (int i = 0; i < count; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < add_pct)
                send(pwl_pkg::OP_ADD, pick_word(span), pick_word(65536));
            else if (roll < 97)
                send(pwl_pkg::OP_EVAL, pick_word(span), $urandom);
            else if (roll < 99)
                send(OP_SPARE, $urandom, $urandom);
            else
                send(pwl_pkg::OP_CLEAR, $urandom, $urandom);
        end
    endtask

    // Result side: ready toggles with random stalls, with some stretches of none.
    initial begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever begin
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge clk);
            if ($urandom_range(0, 3) != 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap_len() + 1) @(posedge clk);
            end
        end
    end

    // Watchdog on cycles in which neither side moves a request or a result.
    always @(posedge clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = pwl_pkg::OP_ADD;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: empty table, one point, extremes, replace, each segment choice.
        send(OP_SPARE, 32'h1234_5678, 32'h0);
        send(pwl_pkg::OP_EVAL, 32'd5, 32'd0);
        send(pwl_pkg::OP_ADD, 32'd100, 32'h0001_0000);
        send(pwl_pkg::OP_EVAL, 32'd100, 32'd0);
        send(pwl_pkg::OP_ADD, 32'd200, 32'h0003_0000);
        send(pwl_pkg::OP_EVAL, 32'd150, 32'd0);
        send(pwl_pkg::OP_EVAL, 32'd100, 32'd0);
        send(pwl_pkg::OP_EVAL, 32'd200, 32'd0);
        send(pwl_pkg::OP_EVAL, 32'd0, 32'd0);
        send(pwl_pkg::OP_EVAL, 32'd333, 32'd0);
        send(pwl_pkg::OP_ADD, 32'd200, 32'hffff_0000);
        send(pwl_pkg::OP_ADD, 32'h8000_0000, 32'h8000_0000);
        send(pwl_pkg::OP_ADD, 32'h7fff_ffff, 32'h7fff_ffff);
        send(pwl_pkg::OP_EVAL, 32'h8000_0000, 32'd0);
        send(pwl_pkg::OP_EVAL, 32'h7fff_ffff, 32'd0);
        send(pwl_pkg::OP_EVAL, 32'h7fff_fff0, 32'd0);
        send(OP_SPARE, 32'd0, 32'd0);
        send(pwl_pkg::OP_CLEAR, 32'd0, 32'd0);
        send(pwl_pkg::OP_EVAL, 32'd1, 32'd0);
        // Steep close pair, then a far query so that the result saturates.
        send(pwl_pkg::OP_ADD, 32'd0, 32'h8000_0000);
        send(pwl_pkg::OP_ADD, 32'd1, 32'h7fff_ffff);
        send(pwl_pkg::OP_EVAL, 32'h7fff_ffff, 32'd0);
        send(pwl_pkg::OP_EVAL, 32'h8000_0000, 32'd0);
        send(pwl_pkg::OP_EVAL, 32'hffff_fffe, 32'd0);
        send(pwl_pkg::OP_CLEAR, 32'd0, 32'd0);

        // Hold off until the block has answered everything.
        s_axis_tvalid <= 1'b0;
        wait (pending == 0);
        @(posedge clk);

        // Random part: narrow spans for replacements, wide spans to fill the table.
        for (int p = 0; p < 14; p++) begin
            case (p % 4)
                0: run_phase(90, 40, 55);
                1: run_phase(110, 1 << 30, 75);
                2: run_phase(100, 1000, 60);
                default: run_phase(80, 20_000, 50);
            endcase
            if ($urandom_range(0, 1) == 0)
                send(pwl_pkg::OP_CLEAR, $urandom, $urandom);
        end

        s_axis_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (400) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
